// File: sv/fbeq_pkg.sv
// Shared types, constants and the per-step decode of the five-band equalizer.
// Used by fbeq_mac, fbeq_seq and five_band_biquad_equalizer_top.
package fbeq_pkg;

   localparam int DATA_W     = 32;
   localparam int NUM_BANDS  = 5;
   localparam int BAND_W     = 3;
   localparam int COEF_DEPTH = 25;
   localparam int COEF_IDX_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_STEPS  = 27;
   localparam int STEP_W     = 5;

   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NUM_STEPS - 1);
   localparam logic [DATA_W-1:0] GAIN_RESET = 32'h0001_0000;
   localparam logic              KIND_SAMPLE = 1'b0;
   localparam logic              KIND_COEF   = 1'b1;

   // multiplicand A source
   typedef enum logic [1:0] {
      ASEL_COEF,
      ASEL_UNIT,
      ASEL_GAIN
   } asel_type;

   // multiplicand B source; BSEL_Y1 is also the fresh band output for gain steps
   typedef enum logic [2:0] {
      BSEL_X0,
      BSEL_X1,
      BSEL_X2,
      BSEL_Y1,
      BSEL_Y2
   } bsel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      asel_type              a_sel;
      bsel_type              b_sel;
      logic [BAND_W-1:0]     band;
      logic [COEF_IDX_W-1:0] coef_idx;
      logic                  neg;       // subtract the product
      logic                  first;     // product starts a fresh sum
      logic                  band_end;  // sum is the band output
   } step_type;

   typedef struct packed {
      logic     idle;
      logic     issue;
      logic     finish;
      step_type op;
   } seq_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [BAND_W-1:0] band;
      logic [DATA_W-1:0] data;
   } band_wr_type;

   function automatic step_type make_step(asel_type a, bsel_type b, int band, int idx,
                                          logic neg, logic first, logic band_end);
      step_type s;
      s.a_sel    = a;
      s.b_sel    = b;
      s.band     = BAND_W'(band);
      s.coef_idx = COEF_IDX_W'(idx);
      s.neg      = neg;
      s.first    = first;
      s.band_end = band_end;
      return s;
   endfunction

   // Product schedule: all band terms first, then the five gain products.
   function automatic step_type step_decode(logic [STEP_W-1:0] step);
      step_type s;
      unique case (step)
         // low band: b0 x0 + b1 x1 + b2 x2 - a1 y1 - a2 y2
         5'd0:  s = make_step(ASEL_COEF, BSEL_X0, 0, 0,  1'b0, 1'b1, 1'b0);
         5'd1:  s = make_step(ASEL_COEF, BSEL_X1, 0, 1,  1'b0, 1'b0, 1'b0);
         5'd2:  s = make_step(ASEL_COEF, BSEL_X2, 0, 2,  1'b0, 1'b0, 1'b0);
         5'd3:  s = make_step(ASEL_COEF, BSEL_Y1, 0, 3,  1'b1, 1'b0, 1'b0);
         5'd4:  s = make_step(ASEL_COEF, BSEL_Y2, 0, 4,  1'b1, 1'b0, 1'b1);
         // mid bands: no b1 term
         5'd5:  s = make_step(ASEL_COEF, BSEL_X0, 1, 5,  1'b0, 1'b1, 1'b0);
         5'd6:  s = make_step(ASEL_COEF, BSEL_X2, 1, 7,  1'b0, 1'b0, 1'b0);
         5'd7:  s = make_step(ASEL_COEF, BSEL_Y1, 1, 8,  1'b1, 1'b0, 1'b0);
         5'd8:  s = make_step(ASEL_COEF, BSEL_Y2, 1, 9,  1'b1, 1'b0, 1'b1);
         5'd9:  s = make_step(ASEL_COEF, BSEL_X0, 2, 10, 1'b0, 1'b1, 1'b0);
         5'd10: s = make_step(ASEL_COEF, BSEL_X2, 2, 12, 1'b0, 1'b0, 1'b0);
         5'd11: s = make_step(ASEL_COEF, BSEL_Y1, 2, 13, 1'b1, 1'b0, 1'b0);
         5'd12: s = make_step(ASEL_COEF, BSEL_Y2, 2, 14, 1'b1, 1'b0, 1'b1);
         5'd13: s = make_step(ASEL_COEF, BSEL_X0, 3, 15, 1'b0, 1'b1, 1'b0);
         5'd14: s = make_step(ASEL_COEF, BSEL_X2, 3, 17, 1'b0, 1'b0, 1'b0);
         5'd15: s = make_step(ASEL_COEF, BSEL_Y1, 3, 18, 1'b1, 1'b0, 1'b0);
         5'd16: s = make_step(ASEL_COEF, BSEL_Y2, 3, 19, 1'b1, 1'b0, 1'b1);
         // high band: unit b0, b2, a1
         5'd17: s = make_step(ASEL_UNIT, BSEL_X0, 4, 0,  1'b0, 1'b1, 1'b0);
         5'd18: s = make_step(ASEL_COEF, BSEL_X1, 4, 21, 1'b0, 1'b0, 1'b0);
         5'd19: s = make_step(ASEL_UNIT, BSEL_X2, 4, 0,  1'b0, 1'b0, 1'b0);
         5'd20: s = make_step(ASEL_UNIT, BSEL_Y1, 4, 0,  1'b1, 1'b0, 1'b0);
         5'd21: s = make_step(ASEL_COEF, BSEL_Y2, 4, 24, 1'b1, 1'b0, 1'b1);
         // gain mix
         5'd22: s = make_step(ASEL_GAIN, BSEL_Y1, 0, 0,  1'b0, 1'b1, 1'b0);
         5'd23: s = make_step(ASEL_GAIN, BSEL_Y1, 1, 0,  1'b0, 1'b0, 1'b0);
         5'd24: s = make_step(ASEL_GAIN, BSEL_Y1, 2, 0,  1'b0, 1'b0, 1'b0);
         5'd25: s = make_step(ASEL_GAIN, BSEL_Y1, 3, 0,  1'b0, 1'b0, 1'b0);
         5'd26: s = make_step(ASEL_GAIN, BSEL_Y1, 4, 0,  1'b0, 1'b0, 1'b0);
         default: s = make_step(ASEL_COEF, BSEL_X0, 0, 0, 1'b0, 1'b0, 1'b0);
      endcase
      return s;
   endfunction

endpackage

// File: sv/five_band_biquad_equalizer_top.sv
// Five-band biquad equalizer, one shared 32x32 multiplier under a step sequencer.
// Sample beat: 27 products (22 band terms, 5 gains) one per cycle; the result is
// registered when the last sum leaves the MAC and the response register is free,
// and the next sample is taken after that hand-over. Coefficient beat: no result.
// Sync active-high reset: gains 1.0; coef table, sample and band history cleared.
module five_band_biquad_equalizer_top import fbeq_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic signed [DATA_W-1:0]    req_sample_in,
   input  logic [COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [DATA_W-1:0]    req_coef_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_mixed_out,
   // gain registers
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   // unity multiplicand for the high band's fixed taps: (x << F) >> F == x
   localparam logic [DATA_W-1:0] UNIT = DATA_W'(1) << FRAC_BITS;

   seq_ctl_type       ctl;
   band_wr_type       band_wr;
   logic [DATA_W-1:0] acc;

   logic req_accept;
   logic start;
   logic coef_wr;
   logic out_free;

   // architectural state
   logic [DATA_W-1:0] gain_ff  [NUM_BANDS];
   logic [DATA_W-1:0] coef_ff  [COEF_DEPTH];
   logic [DATA_W-1:0] y1_ff    [NUM_BANDS];   // band output one back
   logic [DATA_W-1:0] y2_ff    [NUM_BANDS];   // band output two back
   logic [DATA_W-1:0] x0_ff;                  // sample being worked on
   logic [DATA_W-1:0] x1_ff;
   logic [DATA_W-1:0] x2_ff;

   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_valid_ff;

   logic [DATA_W-1:0] a_mux;
   logic [DATA_W-1:0] b_mux;

   // The block takes a beat only between samples; the response register sits
   // between the two sides, so a pending result does not hold off a new beat.
   assign req_stall  = !ctl.idle;
   assign req_accept = req_valid && !req_stall;
   assign start      = req_accept && (req_kind == KIND_SAMPLE);
   assign coef_wr    = req_accept && (req_kind == KIND_COEF) &&
                       (req_coef_index < COEF_IDX_W'(COEF_DEPTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   fbeq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .ctl      (ctl)
   );

   // Operand select for the step being issued. Gain steps read y1, which by
   // then already holds the band's new output.
   always_comb begin
      unique case (ctl.op.a_sel)
         ASEL_COEF: a_mux = coef_ff[ctl.op.coef_idx];
         ASEL_UNIT: a_mux = UNIT;
         ASEL_GAIN: a_mux = gain_ff[ctl.op.band];
         default:   a_mux = '0;
      endcase
      unique case (ctl.op.b_sel)
         BSEL_X0: b_mux = x0_ff;
         BSEL_X1: b_mux = x1_ff;
         BSEL_X2: b_mux = x2_ff;
         BSEL_Y1: b_mux = y1_ff[ctl.op.band];
         BSEL_Y2: b_mux = y2_ff[ctl.op.band];
         default: b_mux = '0;
      endcase
   end

   fbeq_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .issue   (ctl.issue),
      .op      (ctl.op),
      .a_op    ($signed(a_mux)),
      .b_op    ($signed(b_mux)),
      .acc     (acc),
      .band_wr (band_wr)
   );

   // gain registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANDS; i++) begin
            gain_ff[i] <= GAIN_RESET;
         end
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(NUM_BANDS))) begin
         gain_ff[csr_index[BAND_W-1:0]] <= csr_wdata;
      end
   end

   // coefficient table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_DEPTH; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (coef_wr) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   // Band history shifts as soon as a band's sum completes; its own taps
   // were all issued before that point.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANDS; i++) begin
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (band_wr.valid) begin
         y1_ff[band_wr.band] <= band_wr.data;
         y2_ff[band_wr.band] <= y1_ff[band_wr.band];
      end
   end

   // input history shifts when the result is handed to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
      end else if (ctl.finish) begin
         x1_ff <= x0_ff;
         x2_ff <= x1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x0_ff <= req_sample_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_data_ff <= acc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mixed_out = $signed(rsp_data_ff);

endmodule

// File: sv/fbeq_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, then shift and wrap-add.
// Depends on fbeq_pkg.
module fbeq_mac import fbeq_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     issue,
   input  step_type                 op,
   input  logic signed [DATA_W-1:0] a_op,
   input  logic signed [DATA_W-1:0] b_op,
   output logic        [DATA_W-1:0] acc,
   output band_wr_type              band_wr
);

   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic                       valid_ff;
   step_type                   op_ff;
   logic [DATA_W-1:0]          acc_ff, acc_in;
   logic [DATA_W-1:0]          term;
   logic [DATA_W-1:0]          base;

   assign prod_in = a_op * b_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= prod_in;
         op_ff   <= op;
      end
   end

   // floor shift, keep low word
   assign term   = prod_ff[FRAC_BITS +: DATA_W];
   assign base   = op_ff.first ? '0 : acc_ff;
   assign acc_in = op_ff.neg ? base - term : base + term;

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc           = acc_ff;
   assign band_wr.valid = valid_ff && op_ff.band_end;
   assign band_wr.band  = op_ff.band;
   assign band_wr.data  = acc_in;

endmodule

// File: sv/fbeq_seq.sv
// Step sequencer of the equalizer: walks the product schedule once per sample.
// Depends on fbeq_pkg.
module fbeq_seq import fbeq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        out_free,
   output seq_ctl_type ctl
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      ctl.idle   = 1'b0;
      ctl.issue  = 1'b0;
      ctl.finish = 1'b0;
      ctl.op     = step_decode(step_ff);
      unique case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            step_in  = '0;
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.issue = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
